/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/acm_pkg.sv */
// Shared types, constants and helpers of the pattern matcher
package acm_pkg;

  localparam int MAX_NODES   = 256;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int NODE_CNT_W  = NODE_W + 1;
  localparam int MAX_PAT     = 16;
  localparam int PAT_W       = $clog2(MAX_PAT);
  localparam int PAT_CNT_W   = PAT_W + 1;
  localparam int TRIE_AW     = NODE_W + 8;
  localparam int FUNC_W      = 3;
  localparam int KIND_W      = 3;
  localparam int POS_W       = 32;
  localparam int LEN_W       = 8;
  localparam logic [LEN_W-1:0] LEN_MAX = 8'd255;

  typedef enum logic [FUNC_W-1:0] {
    F_CLEAR = 3'd0,
    F_PAT   = 3'd1,
    F_END   = 3'd2,
    F_BUILD = 3'd3,
    F_SCAN  = 3'd4
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    K_MATCH     = 3'd0,
    K_ACCEPTED  = 3'd1,
    K_TRIE_FULL = 3'd2,
    K_PAT_FULL  = 3'd3,
    K_EMPTY     = 3'd4,
    K_NOT_BUILT = 3'd5,
    K_BUILT     = 3'd6
  } kind_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_CLR_REGS, OP_CLR_STEP, OP_LD_RD, OP_LD_HIT, OP_LD_NEW,
    OP_EP_RD, OP_EP_WR, OP_B_INIT, OP_B1_RD, OP_B1_CHK, OP_B2_POP, OP_B2_Q,
    OP_B2_FR, OP_B2_RD, OP_B2_HIT, OP_WALK_RD, OP_B2_FSET, OP_FAIL_RD,
    OP_FAIL_TAKE, OP_B2_OWN, OP_B2_OWN2, OP_B2_OWN3, OP_C_NEXT, OP_B_DONE,
    OP_SC_HIT, OP_SC_OWN, OP_SC_SET, OP_SEL, OP_EMIT, OP_RESP
  } dp_op_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RESP, S_RESP_CLR, S_LD_RD, S_LD_CHK, S_EP_RD,
    S_EP_WR, S_B_INIT, S_B1_RD, S_B1_CHK, S_B2_POP, S_B2_Q, S_B2_FR, S_B2_RD,
    S_B2_CHK, S_B2_WRD, S_B2_WCHK, S_B2_WFL, S_B2_OWN, S_B2_OWN2, S_B2_OWN3,
    S_B2_NXT, S_SC_RD, S_SC_CHK, S_SC_FL, S_SC_OWN, S_SC_SET, S_SEL, S_EMIT
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   kind_we;
    kind_t  kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic trie_nz;
    logic node_root;
    logic c_last;
    logic node_full;
    logic pc_full;
    logic len_full;
    logic len_zero;
    logic built;
    logic q_empty;
    logic own_zero;
    logic sel_last;
    logic set_last;
    logic out_free;
    logic clr_last;
  } dp_stat_t;

  function automatic logic [7:0] fold(input logic [7:0] b, input logic cf);
    logic [7:0] r;
    r = b;
    if (cf && b >= 8'h61 && b <= 8'h7A) r = b - 8'h20;
    return r;
  endfunction

endpackage

/* rtl/acm_if.sv */
// Channel interfaces: input items, result items, configuration writes
interface acm_in_if;
  logic                       valid;
  logic                       ready;
  logic [acm_pkg::FUNC_W-1:0] func;
  logic [7:0]                 data_byte;
  logic [acm_pkg::POS_W-1:0]  position;
  modport source (output valid, func, data_byte, position, input ready);
  modport sink   (input valid, func, data_byte, position, output ready);
endinterface

interface acm_out_if;
  logic                       valid;
  logic                       ready;
  logic [acm_pkg::KIND_W-1:0] kind;
  logic [acm_pkg::PAT_W-1:0]  pattern_index;
  logic [acm_pkg::POS_W-1:0]  match_start;
  logic [acm_pkg::POS_W-1:0]  match_end;
  logic                       last;
  modport source (output valid, kind, pattern_index, match_start, match_end, last,
                  input ready);
  modport sink   (input valid, kind, pattern_index, match_start, match_end, last,
                  output ready);
endinterface

interface acm_cfg_if;
  logic valid;
  logic ready;
  logic case_fold;
  modport source (output valid, case_fold, input ready);
  modport sink   (input valid, case_fold, output ready);
endinterface

/* rtl/aho_corasick_multi_pattern_matcher_unit.sv */
// Top level of the multi-pattern byte matcher
//
//  channel   dir   handshake        payload
//  in_chan   in    valid/ready      func, data_byte, position
//  out_chan  out   valid/ready      kind, pattern_index, match_start, match_end, last
//  cfg_chan  in    valid/ready      case_fold (always ready)
//
// Pattern byte: trie read, edge check, result. End pattern: owner read, write, result.
// Status results go from decode straight to the result. Scan: goto edge read and check,
// a fail hop per miss, the match-set read, then per match a 16-entry length search on
// the pattern length table, one entry a cycle. Build: root edges first, then per queued
// node each edge, and per child a fail walk and match-set merge; bound by the single trie
// memory port. After reset and after a clear command the trie is swept with in_chan not
// ready. A result waiting in the output register stalls the next push.
module aho_corasick_multi_pattern_matcher_unit (
  input logic         clk,
  input logic         rst_n,
  acm_in_if.sink      in_chan,
  acm_out_if.source   out_chan,
  acm_cfg_if.sink     cfg_chan
);
  import acm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_we;

  assign cfg_chan.ready = 1'b1;
  assign cfg_we         = cfg_chan.valid;

  acm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (in_chan.valid),
    .in_rdy (in_chan.ready),
    .stat   (stat),
    .cmd    (cmd)
  );

  acm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_func   (in_chan.func),
    .in_byte   (in_chan.data_byte),
    .in_pos    (in_chan.position),
    .cfg_we    (cfg_we),
    .cfg_fold  (cfg_chan.case_fold),
    .out_rdy   (out_chan.ready),
    .out_vld   (out_chan.valid),
    .out_kind  (out_chan.kind),
    .out_idx   (out_chan.pattern_index),
    .out_start (out_chan.match_start),
    .out_end   (out_chan.match_end),
    .out_last  (out_chan.last)
  );

endmodule

/* rtl/acm_dp.sv */
// Datapath: trie, fail, match-set and queue memories, scalar state, result register
`include "assert_macros.svh"
module acm_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  acm_pkg::dp_cmd_t           cmd,
  output acm_pkg::dp_stat_t          stat,
  input  logic [acm_pkg::FUNC_W-1:0] in_func,
  input  logic [7:0]                 in_byte,
  input  logic [acm_pkg::POS_W-1:0]  in_pos,
  input  logic                       cfg_we,
  input  logic                       cfg_fold,
  input  logic                       out_rdy,
  output logic                       out_vld,
  output logic [acm_pkg::KIND_W-1:0] out_kind,
  output logic [acm_pkg::PAT_W-1:0]  out_idx,
  output logic [acm_pkg::POS_W-1:0]  out_start,
  output logic [acm_pkg::POS_W-1:0]  out_end,
  output logic                       out_last
);
  import acm_pkg::*;

  logic [NODE_W-1:0]  trie_mem [1 << TRIE_AW];
  logic [NODE_W-1:0]  fail_mem [MAX_NODES];
  logic [MAX_PAT-1:0] own_mem  [MAX_NODES];
  logic [NODE_W-1:0]  q_mem    [MAX_NODES];

  logic [NODE_W-1:0]  trie_q, fail_q, q_q;
  logic [MAX_PAT-1:0] own_q;

  logic [NODE_CNT_W-1:0] node_count_r;
  logic [PAT_CNT_W-1:0]  pc_r;
  logic [NODE_W-1:0]     load_node_r, cur_node_r;
  logic [LEN_W-1:0]      load_len_r;
  logic                  built_r, fold_r;
  logic [TRIE_AW-1:0]    clr_r;
  logic [LEN_W-1:0]      plen_r [MAX_PAT];

  logic [FUNC_W-1:0]  func_r;
  logic [7:0]         c_r;
  logic [POS_W-1:0]   pos_r;
  logic [NODE_W-1:0]  node_r, r_r, fr_r, s_r, f_r, head_r, tail_r;
  logic [MAX_PAT-1:0] tmp_r, set_r;
  logic [PAT_W-1:0]   sel_r, best_idx_r;
  logic [LEN_W-1:0]   best_len_r;
  kind_t              kind_r;

  logic                  out_vld_r, out_last_r;
  logic [KIND_W-1:0]     out_kind_r;
  logic [PAT_W-1:0]      out_idx_r;
  logic [POS_W-1:0]      out_start_r, out_end_r;

  logic [TRIE_AW-1:0] tr_addr;
  logic               tr_we, tr_re;
  logic [NODE_W-1:0]  tr_wd;
  logic [NODE_W-1:0]  fl_addr, fl_wd, ow_addr;
  logic               fl_we, fl_re, ow_we, ow_re, q_we, q_re;
  logic [MAX_PAT-1:0] ow_wd, best_bit;
  logic               push;

  assign best_bit = MAX_PAT'(1) << best_idx_r;
  assign push     = (cmd.op == OP_RESP) || (cmd.op == OP_EMIT);

  // memory port selection
  always_comb begin
    tr_addr = {node_r, c_r};
    tr_we   = 1'b0;
    tr_re   = 1'b0;
    tr_wd   = node_count_r[NODE_W-1:0];
    fl_addr = node_r;
    fl_we   = 1'b0;
    fl_re   = 1'b0;
    fl_wd   = '0;
    ow_addr = node_r;
    ow_we   = 1'b0;
    ow_re   = 1'b0;
    ow_wd   = '0;
    q_we    = 1'b0;
    q_re    = 1'b0;
    case (cmd.op)
      OP_CLR_STEP: begin
        tr_addr = clr_r;
        tr_wd   = '0;
        tr_we   = 1'b1;
        ow_addr = clr_r[NODE_W-1:0];
        ow_we   = 1'b1;
      end
      OP_LD_RD, OP_WALK_RD: tr_re = 1'b1;
      OP_LD_NEW: tr_we = 1'b1;
      OP_B1_RD: begin
        tr_addr = {{NODE_W{1'b0}}, c_r};
        tr_re   = 1'b1;
      end
      OP_B2_RD: begin
        tr_addr = {r_r, c_r};
        tr_re   = 1'b1;
      end
      OP_B_INIT: begin
        fl_addr = '0;
        fl_we   = 1'b1;
      end
      OP_B1_CHK: begin
        fl_addr = trie_q;
        fl_we   = (trie_q != '0);
        q_we    = (trie_q != '0);
      end
      OP_B2_HIT: q_we = 1'b1;
      OP_B2_POP: q_re = 1'b1;
      OP_B2_Q: begin
        fl_addr = q_q;
        fl_re   = 1'b1;
      end
      OP_FAIL_RD: fl_re = 1'b1;
      OP_B2_FSET: begin
        fl_addr = s_r;
        fl_wd   = trie_q;
        fl_we   = 1'b1;
      end
      OP_EP_RD: begin
        ow_addr = load_node_r;
        ow_re   = 1'b1;
      end
      OP_EP_WR: begin
        ow_addr = load_node_r;
        ow_wd   = own_q | (MAX_PAT'(1) << pc_r[PAT_W-1:0]);
        ow_we   = 1'b1;
      end
      OP_B2_OWN: begin
        ow_addr = f_r;
        ow_re   = 1'b1;
      end
      OP_B2_OWN2: begin
        ow_addr = s_r;
        ow_re   = 1'b1;
      end
      OP_B2_OWN3: begin
        ow_addr = s_r;
        ow_wd   = own_q | tmp_r;
        ow_we   = 1'b1;
      end
      OP_SC_OWN: ow_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tr_we) trie_mem[tr_addr] <= tr_wd;
    if (tr_re) trie_q <= trie_mem[tr_addr];
  end

  always_ff @(posedge clk) begin
    if (fl_we) fail_mem[fl_addr] <= fl_wd;
    if (fl_re) fail_q <= fail_mem[fl_addr];
  end

  always_ff @(posedge clk) begin
    if (ow_we) own_mem[ow_addr] <= ow_wd;
    if (ow_re) own_q <= own_mem[ow_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[tail_r] <= trie_q;
    if (q_re) q_q <= q_mem[head_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_CNT_W'(1);
      pc_r         <= '0;
      load_node_r  <= '0;
      load_len_r   <= '0;
      cur_node_r   <= '0;
      built_r      <= 1'b0;
      fold_r       <= 1'b0;
      clr_r        <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) fold_r <= cfg_fold;
      if (push) out_vld_r <= 1'b1;
      else if (out_rdy) out_vld_r <= 1'b0;
      case (cmd.op)
        OP_CLR_REGS: begin
          node_count_r <= NODE_CNT_W'(1);
          pc_r         <= '0;
          load_node_r  <= '0;
          load_len_r   <= '0;
          cur_node_r   <= '0;
          built_r      <= 1'b0;
          clr_r        <= '0;
        end
        OP_CLR_STEP: clr_r <= clr_r + TRIE_AW'(1);
        OP_LD_HIT: begin
          load_node_r <= trie_q;
          load_len_r  <= load_len_r + LEN_W'(1);
        end
        OP_LD_NEW: begin
          load_node_r  <= node_count_r[NODE_W-1:0];
          node_count_r <= node_count_r + NODE_CNT_W'(1);
          load_len_r   <= load_len_r + LEN_W'(1);
        end
        OP_EP_WR: begin
          pc_r        <= pc_r + PAT_CNT_W'(1);
          load_node_r <= '0;
          load_len_r  <= '0;
        end
        OP_B_DONE: begin
          load_node_r <= '0;
          load_len_r  <= '0;
          cur_node_r  <= '0;
          built_r     <= 1'b1;
        end
        OP_SC_HIT: cur_node_r <= trie_q;
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (cmd.kind_we) kind_r <= cmd.kind;
    case (cmd.op)
      OP_ACCEPT: begin
        func_r <= in_func;
        c_r    <= fold(in_byte, fold_r);
        pos_r  <= in_pos;
        node_r <= (in_func == F_SCAN) ? cur_node_r : load_node_r;
      end
      OP_EP_WR: plen_r[pc_r[PAT_W-1:0]] <= load_len_r;
      OP_B_INIT: begin
        c_r    <= '0;
        head_r <= '0;
        tail_r <= '0;
      end
      OP_B1_CHK: begin
        c_r <= c_r + 8'd1;
        if (trie_q != '0) tail_r <= tail_r + NODE_W'(1);
      end
      OP_B2_POP: head_r <= head_r + NODE_W'(1);
      OP_B2_Q: begin
        r_r <= q_q;
        c_r <= '0;
      end
      OP_B2_FR: fr_r <= fail_q;
      OP_B2_HIT: begin
        s_r    <= trie_q;
        tail_r <= tail_r + NODE_W'(1);
        node_r <= fr_r;
      end
      OP_B2_FSET: f_r <= trie_q;
      OP_FAIL_TAKE: node_r <= fail_q;
      OP_B2_OWN2: tmp_r <= own_q;
      OP_C_NEXT: c_r <= c_r + 8'd1;
      OP_SC_HIT: node_r <= trie_q;
      OP_SC_SET: begin
        set_r      <= own_q;
        sel_r      <= '0;
        best_len_r <= '0;
      end
      OP_SEL: begin
        // strict compare keeps the lower index on equal length
        if (set_r[sel_r] && plen_r[sel_r] > best_len_r) begin
          best_len_r <= plen_r[sel_r];
          best_idx_r <= sel_r;
        end
        sel_r <= sel_r + PAT_W'(1);
      end
      OP_EMIT: begin
        set_r      <= set_r & ~best_bit;
        sel_r      <= '0;
        best_len_r <= '0;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RESP) begin
      out_kind_r  <= kind_r;
      out_idx_r   <= '0;
      out_start_r <= '0;
      out_end_r   <= '0;
      out_last_r  <= 1'b1;
    end else if (cmd.op == OP_EMIT) begin
      out_kind_r  <= K_MATCH;
      out_idx_r   <= best_idx_r;
      out_start_r <= pos_r - POS_W'(best_len_r) + POS_W'(1);
      out_end_r   <= pos_r;
      out_last_r  <= ((set_r & ~best_bit) == '0);
    end
  end

  assign out_vld   = out_vld_r;
  assign out_kind  = out_kind_r;
  assign out_idx   = out_idx_r;
  assign out_start = out_start_r;
  assign out_end   = out_end_r;
  assign out_last  = out_last_r;

  always_comb begin
    stat.func      = func_r;
    stat.trie_nz   = (trie_q != '0);
    stat.node_root = (node_r == '0);
    stat.c_last    = (c_r == 8'hFF);
    stat.node_full = (node_count_r == NODE_CNT_W'(MAX_NODES));
    stat.pc_full   = (pc_r == PAT_CNT_W'(MAX_PAT));
    stat.len_full  = (load_len_r == LEN_MAX);
    stat.len_zero  = (load_len_r == '0);
    stat.built     = built_r;
    stat.q_empty   = (head_r == tail_r);
    stat.own_zero  = (own_q == '0);
    stat.sel_last  = (sel_r == PAT_W'(MAX_PAT - 1));
    stat.set_last  = ((set_r & ~best_bit) == '0);
    stat.out_free  = !out_vld_r || out_rdy;
    stat.clr_last  = (clr_r == {TRIE_AW{1'b1}});
  end

  `ASSERT_IMPLY(a_cur_node_alloc, clk, rst_n, built_r, {1'b0, cur_node_r} < node_count_r)
  `ASSERT_IMPLY(a_empty_at_root, clk, rst_n, load_len_r == '0, load_node_r == '0)
  `ASSERT_IMPLY(a_pc_bound, clk, rst_n, 1'b1, pc_r <= PAT_CNT_W'(MAX_PAT))
  `ASSERT_NEXT(a_push_shows, clk, rst_n, push, out_vld_r)

endmodule

/* rtl/acm_ctrl.sv */
// Controller state machine sequencing load, build, scan and clear
`include "assert_macros.svh"
module acm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  output logic               in_rdy,
  input  acm_pkg::dp_stat_t  stat,
  output acm_pkg::dp_cmd_t   cmd
);
  import acm_pkg::*;

  ctl_state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_CLEAR;
    else        st_r <= st_nxt;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_CLEAR:    if (stat.clr_last) st_nxt = S_IDLE;
      S_IDLE:     if (in_vld) st_nxt = S_DECODE;
      S_DECODE: begin
        case (stat.func)
          F_CLEAR: st_nxt = S_RESP_CLR;
          F_PAT:   st_nxt = (stat.built || stat.pc_full || stat.len_full) ? S_RESP : S_LD_RD;
          F_END:   st_nxt = (stat.built || stat.pc_full || stat.len_zero) ? S_RESP : S_EP_RD;
          F_BUILD: st_nxt = stat.built ? S_RESP : S_B_INIT;
          F_SCAN:  st_nxt = stat.built ? S_SC_RD : S_RESP;
          default: st_nxt = S_IDLE;
        endcase
      end
      S_RESP:     if (stat.out_free) st_nxt = S_IDLE;
      S_RESP_CLR: if (stat.out_free) st_nxt = S_CLEAR;
      S_LD_RD:    st_nxt = S_LD_CHK;
      S_LD_CHK:   st_nxt = S_RESP;
      S_EP_RD:    st_nxt = S_EP_WR;
      S_EP_WR:    st_nxt = S_RESP;
      S_B_INIT:   st_nxt = S_B1_RD;
      S_B1_RD:    st_nxt = S_B1_CHK;
      S_B1_CHK:   st_nxt = stat.c_last ? S_B2_POP : S_B1_RD;
      S_B2_POP:   st_nxt = stat.q_empty ? S_RESP : S_B2_Q;
      S_B2_Q:     st_nxt = S_B2_FR;
      S_B2_FR:    st_nxt = S_B2_RD;
      S_B2_RD:    st_nxt = S_B2_CHK;
      S_B2_CHK:   st_nxt = stat.trie_nz ? S_B2_WRD : S_B2_NXT;
      S_B2_WRD:   st_nxt = S_B2_WCHK;
      S_B2_WCHK:  st_nxt = (stat.trie_nz || stat.node_root) ? S_B2_OWN : S_B2_WFL;
      S_B2_WFL:   st_nxt = S_B2_WRD;
      S_B2_OWN:   st_nxt = S_B2_OWN2;
      S_B2_OWN2:  st_nxt = S_B2_OWN3;
      S_B2_OWN3:  st_nxt = S_B2_NXT;
      S_B2_NXT:   st_nxt = stat.c_last ? S_B2_POP : S_B2_RD;
      S_SC_RD:    st_nxt = S_SC_CHK;
      S_SC_CHK:   st_nxt = (stat.trie_nz || stat.node_root) ? S_SC_OWN : S_SC_FL;
      S_SC_FL:    st_nxt = S_SC_RD;
      S_SC_OWN:   st_nxt = S_SC_SET;
      S_SC_SET:   st_nxt = stat.own_zero ? S_IDLE : S_SEL;
      S_SEL:      if (stat.sel_last) st_nxt = S_EMIT;
      S_EMIT:     if (stat.out_free) st_nxt = stat.set_last ? S_IDLE : S_SEL;
      default:    st_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op      = OP_NONE;
    cmd.kind_we = 1'b0;
    cmd.kind    = K_ACCEPTED;
    in_rdy      = (st_r == S_IDLE);
    case (st_r)
      S_CLEAR: cmd.op = OP_CLR_STEP;
      S_IDLE:  if (in_vld) cmd.op = OP_ACCEPT;
      S_DECODE: begin
        cmd.kind_we = 1'b1;
        case (stat.func)
          F_CLEAR: cmd.op = OP_CLR_REGS;
          F_PAT: begin
            if (stat.built)        cmd.kind = K_BUILT;
            else if (stat.pc_full) cmd.kind = K_PAT_FULL;
            else if (stat.len_full) cmd.kind = K_TRIE_FULL;
            else cmd.op = OP_LD_RD;
          end
          F_END: begin
            if (stat.built)         cmd.kind = K_BUILT;
            else if (stat.pc_full)  cmd.kind = K_PAT_FULL;
            else if (stat.len_zero) cmd.kind = K_EMPTY;
          end
          F_BUILD: if (stat.built) cmd.kind = K_BUILT;
          F_SCAN:  if (!stat.built) cmd.kind = K_NOT_BUILT;
          default: cmd.kind_we = 1'b0;
        endcase
      end
      S_RESP, S_RESP_CLR: if (stat.out_free) cmd.op = OP_RESP;
      S_LD_RD: cmd.op = OP_LD_RD;
      S_LD_CHK: begin
        cmd.kind_we = 1'b1;
        if (stat.trie_nz)        cmd.op = OP_LD_HIT;
        else if (stat.node_full) cmd.kind = K_TRIE_FULL;
        else                     cmd.op = OP_LD_NEW;
      end
      S_EP_RD:   cmd.op = OP_EP_RD;
      S_EP_WR: begin
        cmd.op      = OP_EP_WR;
        cmd.kind_we = 1'b1;
      end
      S_B_INIT:  cmd.op = OP_B_INIT;
      S_B1_RD:   cmd.op = OP_B1_RD;
      S_B1_CHK:  cmd.op = OP_B1_CHK;
      S_B2_POP: begin
        if (stat.q_empty) begin
          cmd.op      = OP_B_DONE;
          cmd.kind_we = 1'b1;
        end else begin
          cmd.op = OP_B2_POP;
        end
      end
      S_B2_Q:    cmd.op = OP_B2_Q;
      S_B2_FR:   cmd.op = OP_B2_FR;
      S_B2_RD:   cmd.op = OP_B2_RD;
      S_B2_CHK:  if (stat.trie_nz) cmd.op = OP_B2_HIT;
      S_B2_WRD:  cmd.op = OP_WALK_RD;
      S_B2_WCHK: cmd.op = (stat.trie_nz || stat.node_root) ? OP_B2_FSET : OP_FAIL_RD;
      S_B2_WFL:  cmd.op = OP_FAIL_TAKE;
      S_B2_OWN:  cmd.op = OP_B2_OWN;
      S_B2_OWN2: cmd.op = OP_B2_OWN2;
      S_B2_OWN3: cmd.op = OP_B2_OWN3;
      S_B2_NXT:  cmd.op = OP_C_NEXT;
      S_SC_RD:   cmd.op = OP_WALK_RD;
      S_SC_CHK:  cmd.op = (stat.trie_nz || stat.node_root) ? OP_SC_HIT : OP_FAIL_RD;
      S_SC_FL:   cmd.op = OP_FAIL_TAKE;
      S_SC_OWN:  cmd.op = OP_SC_OWN;
      S_SC_SET:  cmd.op = OP_SC_SET;
      S_SEL:     cmd.op = OP_SEL;
      S_EMIT:    if (stat.out_free) cmd.op = OP_EMIT;
      default: ;
    endcase
  end

  `ASSERT_NEXT(a_accept_decodes, clk, rst_n, st_r == S_IDLE && in_vld, st_r == S_DECODE)
  `ASSERT_IMPLY(a_push_needs_room, clk, rst_n, cmd.op == OP_RESP || cmd.op == OP_EMIT,
                stat.out_free)
  `ASSERT_NEXT(a_clear_after_resp, clk, rst_n, st_r == S_RESP_CLR && stat.out_free,
               st_r == S_CLEAR)

endmodule

/* tb/aho_corasick_multi_pattern_matcher_unit_test.sv */
// Testbench for the multi-pattern byte matcher: directed and random phases, scoreboard check
`timescale 1ns / 100ps

module aho_corasick_multi_pattern_matcher_unit_test;
  import acm_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct {
    kind_t     kind;
    bit [3:0]  idx;
    bit [31:0] mstart;
    bit [31:0] mend;
    bit        last;
  } match_rec_t;

  class match_scoreboard;
    match_rec_t expq[$];
    bit [7:0]  trie_to[65536];
    bit        trie_ok[65536];
    bit [7:0]  fail_of[256];
    bit [15:0] owns[256];
    bit [7:0]  plen[16];
    int        node_cnt, pat_cnt, ld_len;
    bit [7:0]  ld_node, cur;
    bit        is_built, cf;
    int        errors;

    function new();
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < 65536; i++) begin
        trie_ok[i] = 0;
        trie_to[i] = 0;
      end
      for (int i = 0; i < 256; i++) begin
        fail_of[i] = 0;
        owns[i] = 0;
      end
      for (int i = 0; i < 16; i++) plen[i] = 0;
      node_cnt = 1;
      pat_cnt = 0;
      ld_len = 0;
      ld_node = 0;
      cur = 0;
      is_built = 0;
    endfunction

    function bit [7:0] up(bit [7:0] b);
      if (cf && b >= 8'h61 && b <= 8'h7A) return b - 8'h20;
      return b;
    endfunction

    function void push_status(kind_t k);
      expq.push_back('{k, 4'd0, 32'd0, 32'd0, 1'b1});
    endfunction

    function void build_trie();
      bit [7:0] q[256];
      int head, tail, guard;
      bit [7:0] r, s, st, f;
      head = 0;
      tail = 0;
      for (int c = 0; c < 256; c++)
        if (!trie_ok[c]) begin
          trie_ok[c] = 1;
          trie_to[c] = 0;
        end
      fail_of[0] = 0;
      for (int c = 0; c < 256; c++) begin
        s = trie_to[c];
        if (s != 0 && tail < 256) begin
          fail_of[s] = 0;
          q[tail++] = s;
        end
      end
      while (head < tail) begin
        r = q[head++];
        for (int c = 0; c < 256; c++) begin
          if (!trie_ok[{r, c[7:0]}]) continue;
          s = trie_to[{r, c[7:0]}];
          if (tail < 256) q[tail++] = s;
          st = fail_of[r];
          guard = 0;
          while (!trie_ok[{st, c[7:0]}] && guard < 256) begin
            st = fail_of[st];
            guard++;
          end
          f = trie_ok[{st, c[7:0]}] ? trie_to[{st, c[7:0]}] : 8'd0;
          fail_of[s] = f;
          owns[s] |= owns[f];
        end
      end
      ld_node = 0;
      ld_len = 0;
      cur = 0;
      is_built = 1;
    endfunction

    function void scan_byte(bit [7:0] b, bit [31:0] pos);
      bit [7:0] c, node;
      bit [3:0] hits[16];
      int guard, n, j;
      c = up(b);
      node = cur;
      guard = 0;
      n = 0;
      while (!trie_ok[{node, c}] && guard < 256) begin
        node = fail_of[node];
        guard++;
      end
      node = trie_ok[{node, c}] ? trie_to[{node, c}] : 8'd0;
      cur = node;
      for (int i = 0; i < pat_cnt && i < 16; i++)
        if (owns[node][i]) begin
          j = n;
          // longest first, equal lengths keep load order
          while (j > 0 && plen[hits[j-1]] < plen[i]) begin
            hits[j] = hits[j-1];
            j--;
          end
          hits[j] = i[3:0];
          n++;
        end
      for (int i = 0; i < n; i++)
        expq.push_back('{K_MATCH, hits[i], pos - (32'(plen[hits[i]]) - 32'd1), pos,
                         (i + 1 == n)});
    endfunction

    function void note_input(bit [2:0] f, bit [7:0] b, bit [31:0] pos);
      bit [15:0] e;
      case (f)
        F_CLEAR: begin
          wipe();
          push_status(K_ACCEPTED);
        end
        F_PAT: begin
          if (is_built) push_status(K_BUILT);
          else if (pat_cnt >= 16) push_status(K_PAT_FULL);
          else if (ld_len >= 255) push_status(K_TRIE_FULL);
          else begin
            e = {ld_node, up(b)};
            if (!trie_ok[e] && node_cnt >= 256) push_status(K_TRIE_FULL);
            else begin
              if (!trie_ok[e]) begin
                trie_ok[e] = 1;
                trie_to[e] = node_cnt[7:0];
                node_cnt++;
              end
              ld_node = trie_to[e];
              ld_len++;
              push_status(K_ACCEPTED);
            end
          end
        end
        F_END: begin
          if (is_built) push_status(K_BUILT);
          else if (pat_cnt >= 16) push_status(K_PAT_FULL);
          else if (ld_len == 0) push_status(K_EMPTY);
          else begin
            owns[ld_node][pat_cnt] = 1'b1;
            plen[pat_cnt] = ld_len[7:0];
            pat_cnt++;
            ld_node = 0;
            ld_len = 0;
            push_status(K_ACCEPTED);
          end
        end
        F_BUILD: begin
          if (is_built) push_status(K_BUILT);
          else begin
            build_trie();
            push_status(K_ACCEPTED);
          end
        end
        F_SCAN: begin
          if (!is_built) push_status(K_NOT_BUILT);
          else scan_byte(b, pos);
        end
        default: ;
      endcase
    endfunction

    function void check_result(bit [2:0] k, bit [3:0] idx, bit [31:0] ms, bit [31:0] me,
                               bit l);
      match_rec_t x;
      if (expq.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result kind=%0d idx=%0d start=%h end=%h last=%0d",
                   k, idx, ms, me, l);
        return;
      end
      x = expq.pop_front();
      if (k !== x.kind || idx !== x.idx || ms !== x.mstart || me !== x.mend ||
          l !== x.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp kind=%0d idx=%0d start=%h end=%h last=%0d | got %0d %0d %h %h %0d",
                   x.kind, x.idx, x.mstart, x.mend, x.last, k, idx, ms, me, l);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  acm_in_if  in_if();
  acm_out_if out_if();
  acm_cfg_if cfg_if();

  aho_corasick_multi_pattern_matcher_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  match_scoreboard sb = new();
  int cycles = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit quiet = 0;
  bit [31:0] scan_pos;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    in_if.valid = 0;
    in_if.func = 0;
    in_if.data_byte = 0;
    in_if.position = 0;
    out_if.ready = 1;
    cfg_if.valid = 0;
    cfg_if.case_fold = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check every transfer, then pick next ready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.kind, out_if.pattern_index, out_if.match_start,
                        out_if.match_end, out_if.last);
      if (hold_left > 0) begin
        out_if.ready <= 0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_if.ready <= 0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 0;
        stall_left = $urandom_range(0, 12);
      end else
        out_if.ready <= 1;
    end
  end

  task automatic send(bit [2:0] f, bit [7:0] b = 8'h00, bit [31:0] pos = 32'd0);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_if.valid <= 1;
    in_if.func <= f;
    in_if.data_byte <= b;
    in_if.position <= pos;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(f, b, pos);
  endtask

  task automatic scan_next(bit [7:0] b);
    if ($urandom_range(0, 15) == 0) scan_pos = $urandom;
    send(F_SCAN, b, scan_pos);
    scan_pos++;
  endtask

  task automatic drain();
    in_if.valid <= 0;
    while (sb.expq.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_fold(bit v);
    cfg_if.valid <= 1;
    cfg_if.case_fold <= v;
    do @(posedge clk); while (!cfg_if.ready);
    sb.cf = v;
    cfg_if.valid <= 0;
  endtask

  task automatic send_word(string w);
    foreach (w[i]) send(F_PAT, w[i]);
    send(F_END);
  endtask

  function automatic bit [7:0] pick_char();
    bit [7:0] abc[4] = '{8'h61, 8'h62, 8'h41, 8'h42};
    if ($urandom_range(0, 15) == 0) return 8'($urandom);
    return abc[$urandom_range(0, 3)];
  endfunction

  // clear, load random short patterns, build, scan random text; stray and unused codes mixed in
  task automatic random_phase(bit fold, int npat, int nscan);
    int len;
    write_fold(fold);
    send(F_CLEAR);
    for (int p = 0; p < npat; p++) begin
      len = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) send(F_PAT, pick_char());
      send(F_END);
      if ($urandom_range(0, 7) == 0) send(3'($urandom_range(5, 7)), 8'($urandom), $urandom);
    end
    if ($urandom_range(0, 1)) send(F_PAT, pick_char());
    send(F_BUILD);
    scan_pos = $urandom;
    for (int i = 0; i < nscan; i++) begin
      case ($urandom_range(0, 19))
        0: send(3'($urandom_range(F_PAT, F_BUILD)), 8'($urandom), $urandom);
        1: send(3'($urandom_range(5, 7)), 8'($urandom), $urandom);
        default: scan_next(pick_char());
      endcase
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: status codes, wrap of match start, extreme bytes, unused codes
    write_fold(0);
    send(F_SCAN, 8'h68, 32'd0);
    send(F_END);
    send_word("he");
    send_word("She");
    send(F_PAT, 8'h00);
    send(F_PAT, 8'hFF);
    send(F_END);
    send(F_PAT, 8'h78);
    send(F_BUILD);
    send(F_PAT, 8'h61);
    send(F_END);
    send(F_BUILD);
    send(3'd5, 8'hFF, 32'hFFFF_FFFF);
    send(3'd6);
    send(3'd7);
    send(F_SCAN, 8'h53, 32'hFFFF_FFFE);
    send(F_SCAN, 8'h68, 32'hFFFF_FFFF);
    send(F_SCAN, 8'h65, 32'h0000_0000);
    send(F_SCAN, 8'h00, 32'h0000_0001);
    send(F_SCAN, 8'hFF, 32'h8000_0000);
    send(F_SCAN, 8'h78, 32'h0000_0003);
    drain();

    // sixteen nested patterns of 'a', then pattern limit; scans under a long stall
    write_fold(1);
    send(F_CLEAR);
    for (int p = 0; p < 16; p++) begin
      for (int i = 0; i <= p % 3; i++) send(F_PAT, $urandom_range(0, 1) ? 8'h61 : 8'h41);
      send(F_END);
    end
    send(F_PAT, 8'h61);
    send(F_END);
    send(F_BUILD);
    hold_left = 400;
    scan_pos = 32'd2;
    for (int i = 0; i < 12; i++) scan_next($urandom_range(0, 3) ? 8'h61 : 8'h41);
    drain();

    random_phase(1, 3, 8);
    quiet = 1;
    random_phase(1'($urandom_range(0, 1)), 3, 10);

    if (sb.errors == 0 && sb.expq.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
